// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions on a single clock and reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition must never be seen on a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// File: hw/rtl/las_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// las_pkg
// Types and constants shared by the latency statistics accumulator.
// ----------------------------------------------------------------------------
package las_pkg;

    // Field widths of the stream payloads
    localparam int OUTCOME_BITS   = 2;
    localparam int RTT_FIELD_BITS = 24;
    localparam int CNT_FIELD_BITS = 32;
    localparam int SEQ_BITS       = 32;
    localparam int SKIP_BITS      = 16;
    localparam int LOSS_BITS      = 10;

    // Loss is reported in tenths of a percent
    localparam int LOSS_SCALE     = 1000;

    // Input stream packing
    localparam int IN_DATA_BITS   = 24;
    localparam int IN_USER_BITS   = 8;

    // Output stream packing (bit offsets within tdata)
    localparam int OUT_DATA_BITS  = 264;
    localparam int OUT_PAD_BITS   = 6;
    localparam int OUT_MIN_LSB    = 128;
    localparam int OUT_MAX_LSB    = 152;
    localparam int OUT_LOSS_LSB   = 248;

    // Probe outcome codes
    localparam logic [OUTCOME_BITS-1:0] OUTCOME_SUCCESS = 2'd0;
    localparam logic [OUTCOME_BITS-1:0] OUTCOME_TIMEOUT = 2'd1;
    localparam logic [OUTCOME_BITS-1:0] OUTCOME_ERROR   = 2'd2;

    // Which quotient the shared divider is working on
    typedef enum logic [1:0] {
        DIV_AVG,
        DIV_JIT,
        DIV_LOSS
    } div_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic     capture;
        logic     update;
        logic     mult;
        logic     div_start;
        logic     div_store;
        div_sel_t div_sel;
        logic     load_out;
    } las_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;
        logic out_free;
    } las_stat_t;

    // One result item
    typedef struct packed {
        logic [SEQ_BITS-1:0]       sequence_res;
        logic                      skipped;
        logic [CNT_FIELD_BITS-1:0] pings;
        logic [CNT_FIELD_BITS-1:0] successes;
        logic [CNT_FIELD_BITS-1:0] failures;
        logic [RTT_FIELD_BITS-1:0] rtt_min;
        logic [RTT_FIELD_BITS-1:0] rtt_max;
        logic [RTT_FIELD_BITS-1:0] rtt_average;
        logic [RTT_FIELD_BITS-1:0] rtt_range;
        logic [RTT_FIELD_BITS-1:0] jitter;
        logic [LOSS_BITS-1:0]      loss_permille;
    } las_result_t;

endpackage

// File: hw/rtl/latency_statistics_accumulator.sv
// One request is taken at a time; the next is accepted only after the result
// is handed to the output register. Average, jitter and loss share one
// bit-serial divider (one quotient bit per cycle), max(RTT_BITS+COUNT_BITS
// capped at 64, COUNT_BITS+10) bits wide.
// A finished result may wait in the output register while the next is taken.
// Reset: asynchronous, clears all totals and the skip count, no clearing pass.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latency_statistics_accumulator
// Round-trip time statistics: counts, min/max, mean, jitter and loss.
// ----------------------------------------------------------------------------
module latency_statistics_accumulator
    import las_pkg::*;
#(
    parameter int RTT_BITS   = 24,
    parameter int COUNT_BITS = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    // Configuration: skip_count
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [SKIP_BITS-1:0]     cfg_data,

    // Probe requests
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,   // [23:0] rtt_us
    input  logic [IN_USER_BITS-1:0]  s_axis_tuser,   // [1:0] outcome, [7:2] zero

    // Statistics results
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,   // sequence_res, pings, successes,
                                                     // failures, rtt_min, rtt_max,
                                                     // rtt_average, rtt_range, jitter,
                                                     // loss_permille, zero pad
    output logic                     m_axis_tuser    // skipped
);

    las_cmd_t    cmd;
    las_stat_t   stat;
    las_result_t result;

    // Configuration is always taken; the user must write only while idle, the block does not enforce it
    assign cfg_ready = 1'b1;

    las_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    las_datapath #(
        .RTT_BITS   (RTT_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_outcome (s_axis_tuser[OUTCOME_BITS-1:0]),
        .in_rtt     (s_axis_tdata[RTT_FIELD_BITS-1:0]),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_skip   (cfg_data),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    // Pack result, first field in the lowest bits
    assign m_axis_tdata = {{OUT_PAD_BITS{1'b0}},
                           result.loss_permille,
                           result.jitter,
                           result.rtt_range,
                           result.rtt_average,
                           result.rtt_max,
                           result.rtt_min,
                           result.failures,
                           result.successes,
                           result.pings,
                           result.sequence_res};
    assign m_axis_tuser = result.skipped;

endmodule

// File: hw/rtl/las_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// las_divider
// Restoring divider, one quotient bit per cycle. Quotient is valid when done
// pulses and holds until the next start.
// ----------------------------------------------------------------------------
module las_divider
#(
    parameter int N = 56,
    parameter int D = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [N-1:0] num,
    input  logic [D-1:0] den,
    output logic [N-1:0] quot,
    output logic         done
);

    localparam int CNT_W = $clog2(N + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [N-1:0]     num_reg;
    logic [D-1:0]     den_reg;
    logic [D-1:0]     rem_reg;

    logic [D:0]       rem_shift;
    logic [D:0]       rem_diff;
    logic             fits;
    logic             last;

    // Trial subtraction of one step
    assign rem_shift = {rem_reg, num_reg[N-1]};
    assign rem_diff  = rem_shift - (D+1)'(den_reg);
    assign fits      = rem_shift >= (D+1)'(den_reg);
    assign last      = cnt_reg == CNT_W'(1);

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(N);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Shift register: dividend bits out, quotient bits in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[N-2:0], fits};
            rem_reg <= fits ? rem_diff[D-1:0] : rem_shift[D-1:0];
        end
    end

    assign quot = num_reg;
    assign done = done_reg;

endmodule

// File: hw/rtl/las_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// las_ctrl
// Sequencer: takes a request, updates the totals, runs the three divisions on
// the shared divider and hands the result to the output register.
// ----------------------------------------------------------------------------
module las_ctrl
    import las_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  las_stat_t stat,
    output las_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_MULT,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_DONE
    } state_t;

    state_t   state_reg;
    div_sel_t sel_reg;

    // State and division select
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg   <= DIV_AVG;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_UPDATE;
                        sel_reg   <= DIV_AVG;
                    end
                end
                ST_UPDATE:    state_reg <= ST_MULT;
                ST_MULT:      state_reg <= ST_DIV_START;
                ST_DIV_START: state_reg <= ST_DIV_WAIT;
                ST_DIV_WAIT:
                begin
                    if (stat.div_done)
                    begin
                        case (sel_reg)
                            DIV_AVG:
                            begin
                                sel_reg   <= DIV_JIT;
                                state_reg <= ST_DIV_START;
                            end
                            DIV_JIT:
                            begin
                                sel_reg   <= DIV_LOSS;
                                state_reg <= ST_DIV_START;
                            end
                            default: state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_DONE:
                begin
                    if (stat.out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Commands decoded from state
    always_comb
    begin
        cmd         = '0;
        cmd.div_sel = sel_reg;
        case (state_reg)
            ST_IDLE:      cmd.capture   = in_valid;
            ST_UPDATE:    cmd.update    = 1'b1;
            ST_MULT:      cmd.mult      = 1'b1;
            ST_DIV_START: cmd.div_start = 1'b1;
            ST_DIV_WAIT:  cmd.div_store = stat.div_done;
            ST_DONE:      cmd.load_out  = stat.out_free;
            default:      cmd.capture   = 1'b0;
        endcase
    end

    assign in_ready = state_reg == ST_IDLE;

endmodule

// File: hw/rtl/las_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// las_datapath
// Running totals, extremes and jitter state, the loss product, the shared
// divider with saturation, and the output register.
// ----------------------------------------------------------------------------
module las_datapath
    import las_pkg::*;
#(
    parameter int RTT_BITS   = 24,
    parameter int COUNT_BITS = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  las_cmd_t                  cmd,
    output las_stat_t                 stat,
    input  logic [OUTCOME_BITS-1:0]   in_outcome,
    input  logic [RTT_FIELD_BITS-1:0] in_rtt,
    input  logic                      cfg_write,
    input  logic [SKIP_BITS-1:0]      cfg_skip,
    output logic                      out_valid,
    input  logic                      out_ready,
    output las_result_t               out_result
);

    // Stored times are limited by both the field and the configured width
    localparam int RV_BITS   = (RTT_BITS < RTT_FIELD_BITS) ? RTT_BITS : RTT_FIELD_BITS;
    localparam int SUM_RAW   = RTT_BITS + COUNT_BITS;
    localparam int SUM_BITS  = (SUM_RAW > 64) ? 64 : SUM_RAW;
    localparam int LNUM_BITS = COUNT_BITS + LOSS_BITS;
    localparam int DIV_BITS  = (SUM_BITS > LNUM_BITS) ? SUM_BITS : LNUM_BITS;

    localparam logic [DIV_BITS-1:0] RTT_LIMIT  = DIV_BITS'({RTT_BITS{1'b1}});
    localparam logic [DIV_BITS-1:0] LOSS_LIMIT = DIV_BITS'(LOSS_SCALE);

    // Captured request
    logic [OUTCOME_BITS-1:0]   outcome_reg;
    logic [RV_BITS-1:0]        rtt_reg;

    // Statistics state
    logic [SEQ_BITS-1:0]       seq_reg;
    logic [SKIP_BITS-1:0]      skip_left_reg;
    logic                      skipped_reg;
    logic [COUNT_BITS-1:0]     ping_reg;
    logic [COUNT_BITS-1:0]     succ_reg;
    logic [COUNT_BITS-1:0]     fail_reg;
    logic [COUNT_BITS-1:0]     pairs_reg;
    logic [SUM_BITS-1:0]       sum_reg;
    logic [SUM_BITS-1:0]       jsum_reg;
    logic [RV_BITS-1:0]        min_reg;
    logic [RV_BITS-1:0]        max_reg;
    logic [RV_BITS-1:0]        prev_reg;
    logic                      prev_valid_reg;

    // Derived results
    logic [LNUM_BITS-1:0]      loss_num_reg;
    logic [RTT_FIELD_BITS-1:0] avg_reg;
    logic [RTT_FIELD_BITS-1:0] jit_reg;
    logic [LOSS_BITS-1:0]      loss_reg;

    // Output register
    logic                      out_valid_reg;
    las_result_t               out_reg;

    logic                      is_success;
    logic [RV_BITS-1:0]        rtt_diff;
    logic [DIV_BITS-1:0]       div_num;
    logic [COUNT_BITS-1:0]     div_den;
    logic [DIV_BITS-1:0]       div_quot;
    logic                      div_done;
    logic [DIV_BITS-1:0]       rtt_sat;
    logic [DIV_BITS-1:0]       loss_sat;

    // Success needs a nonzero time; any other code is a failure
    assign is_success = (outcome_reg == OUTCOME_SUCCESS) && (rtt_reg != '0);
    assign rtt_diff   = (prev_reg > rtt_reg) ? (prev_reg - rtt_reg) : (rtt_reg - prev_reg);

    // Capture request
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            outcome_reg <= in_outcome;
            rtt_reg     <= in_rtt[RV_BITS-1:0];
        end
    end

    // Statistics update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg        <= '0;
            skip_left_reg  <= '0;
            skipped_reg    <= 1'b0;
            ping_reg       <= '0;
            succ_reg       <= '0;
            fail_reg       <= '0;
            pairs_reg      <= '0;
            sum_reg        <= '0;
            jsum_reg       <= '0;
            min_reg        <= '0;
            max_reg        <= '0;
            prev_reg       <= '0;
            prev_valid_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            skip_left_reg <= cfg_skip;
        end
        else if (cmd.update)
        begin
            seq_reg <= seq_reg + SEQ_BITS'(1);
            if (skip_left_reg != '0)
            begin
                skip_left_reg <= skip_left_reg - SKIP_BITS'(1);
                skipped_reg   <= 1'b1;
            end
            else
            begin
                skipped_reg <= 1'b0;
                ping_reg    <= ping_reg + COUNT_BITS'(1);
                if (is_success)
                begin
                    succ_reg <= succ_reg + COUNT_BITS'(1);
                    sum_reg  <= sum_reg + SUM_BITS'(rtt_reg);
                    prev_reg <= rtt_reg;
                    if (prev_valid_reg)
                    begin
                        jsum_reg  <= jsum_reg + SUM_BITS'(rtt_diff);
                        pairs_reg <= pairs_reg + COUNT_BITS'(1);
                        if (rtt_reg < min_reg)
                        begin
                            min_reg <= rtt_reg;
                        end
                        if (rtt_reg > max_reg)
                        begin
                            max_reg <= rtt_reg;
                        end
                    end
                    else
                    begin
                        // first success sets both extremes
                        min_reg        <= rtt_reg;
                        max_reg        <= rtt_reg;
                        prev_valid_reg <= 1'b1;
                    end
                end
                else
                begin
                    fail_reg <= fail_reg + COUNT_BITS'(1);
                end
            end
        end
    end

    // Divider operand select
    always_comb
    begin
        case (cmd.div_sel)
            DIV_AVG:
            begin
                div_num = DIV_BITS'(sum_reg);
                div_den = succ_reg;
            end
            DIV_JIT:
            begin
                div_num = DIV_BITS'(jsum_reg);
                div_den = pairs_reg;
            end
            DIV_LOSS:
            begin
                div_num = DIV_BITS'(loss_num_reg);
                div_den = ping_reg;
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    las_divider #(
        .N (DIV_BITS),
        .D (COUNT_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .quot  (div_quot),
        .done  (div_done)
    );

    // Zero divisor gives 0; large quotients clamp
    always_comb
    begin
        if (div_den == '0)
        begin
            rtt_sat  = '0;
            loss_sat = '0;
        end
        else
        begin
            rtt_sat  = (div_quot > RTT_LIMIT) ? RTT_LIMIT : div_quot;
            loss_sat = (div_quot > LOSS_LIMIT) ? LOSS_LIMIT : div_quot;
        end
    end

    // Loss numerator and quotient capture
    always_ff @(posedge clk)
    begin
        if (cmd.mult)
        begin
            loss_num_reg <= LNUM_BITS'(fail_reg) * LNUM_BITS'(LOSS_SCALE);
        end
        if (cmd.div_store)
        begin
            case (cmd.div_sel)
                DIV_AVG:  avg_reg  <= RTT_FIELD_BITS'(rtt_sat);
                DIV_JIT:  jit_reg  <= RTT_FIELD_BITS'(rtt_sat);
                DIV_LOSS: loss_reg <= LOSS_BITS'(loss_sat);
                default:  loss_reg <= loss_reg;
            endcase
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg.sequence_res  <= seq_reg;
            out_reg.skipped       <= skipped_reg;
            out_reg.pings         <= CNT_FIELD_BITS'(ping_reg);
            out_reg.successes     <= CNT_FIELD_BITS'(succ_reg);
            out_reg.failures      <= CNT_FIELD_BITS'(fail_reg);
            out_reg.rtt_min       <= RTT_FIELD_BITS'(min_reg);
            out_reg.rtt_max       <= RTT_FIELD_BITS'(max_reg);
            out_reg.rtt_average   <= avg_reg;
            out_reg.rtt_range     <= RTT_FIELD_BITS'(max_reg - min_reg);
            out_reg.jitter        <= jit_reg;
            out_reg.loss_permille <= loss_reg;
        end
    end

    assign stat.div_done = div_done;
    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_result    = out_reg;

endmodule

// File: hw/rtl/las_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// las_checker
// Port-level checks for the latency statistics accumulator, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module las_checker
    import las_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     s_axis_tvalid,
    input logic                     s_axis_tready,
    input logic                     m_axis_tvalid,
    input logic                     m_axis_tready,
    input logic [OUT_DATA_BITS-1:0] m_axis_tdata
);

    localparam logic [LOSS_BITS-1:0] LOSS_LIMIT = LOSS_BITS'(LOSS_SCALE);

    logic                      out_wait;
    logic                      in_take;
    logic [LOSS_BITS-1:0]      loss_seen;
    logic [RTT_FIELD_BITS-1:0] min_seen;
    logic [RTT_FIELD_BITS-1:0] max_seen;

    // Handshake terms and result fields under test
    assign out_wait  = m_axis_tvalid && !m_axis_tready;
    assign in_take   = s_axis_tvalid && s_axis_tready;
    assign loss_seen = m_axis_tdata[OUT_LOSS_LSB +: LOSS_BITS];
    assign min_seen  = m_axis_tdata[OUT_MIN_LSB +: RTT_FIELD_BITS];
    assign max_seen  = m_axis_tdata[OUT_MAX_LSB +: RTT_FIELD_BITS];

    // A result stays offered until taken
    `ASSERT_CLK(a_out_hold, clk, rst_n, out_wait |=> m_axis_tvalid, "result dropped before taken")

    // One request in flight: ready drops right after an accept
    `ASSERT_CLK(a_one_in_flight, clk, rst_n, in_take |=> !s_axis_tready, "request taken while busy")

    // Loss never above one thousand permille
    `ASSERT_NEVER(a_loss_range, clk, rst_n, m_axis_tvalid && (loss_seen > LOSS_LIMIT), "loss above 1000")

    // Minimum never above maximum
    `ASSERT_NEVER(a_min_max, clk, rst_n, m_axis_tvalid && (min_seen > max_seen), "rtt_min above rtt_max")

endmodule

bind latency_statistics_accumulator las_checker u_las_checker (.*);

// File: sim/latency_statistics_accumulator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latency_statistics_accumulator_tb
// Self-checking bench for the round-trip time statistics block. Probe
// requests go in over the slave stream; every request is run through a local
// statistics model at accept time. Each result on the master stream is
// compared field by field with the oldest predicted record. Covers all
// outcome codes, time extremes, skip windows, output back-pressure and a long
// random run with skip setting changes between phases.
// ----------------------------------------------------------------------------
module latency_statistics_accumulator_tb;
    import las_pkg::*;

    localparam int  CLK_HALF       = 4;
    localparam int  RESET_CYCLES   = 7;
    localparam int  RESULT_LATENCY = 177;
    localparam int  HOLD_CYCLES    = 900;
    localparam int  CYCLE_LIMIT    = 2_000_000;
    localparam int  IDLE_PERCENT   = 29;
    localparam int  RANDOM_PHASES  = 5;
    localparam int  PHASE_REQUESTS = 300;

    localparam logic [OUTCOME_BITS-1:0]   OUTCOME_UNUSED = 2'd3;
    localparam logic [RTT_FIELD_BITS-1:0] RTT_TOP        = '1;
    localparam logic [SKIP_BITS-1:0]      SKIP_TOP       = '1;

    // DUT signals, all inputs known from time zero
    logic                     clk           = 1'b0;
    logic                     rst_n         = 1'b0;
    logic                     cfg_valid     = 1'b0;
    logic                     cfg_ready;
    logic [SKIP_BITS-1:0]     cfg_data      = '0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_DATA_BITS-1:0]  s_axis_tdata  = '0;   // [23:0] rtt_us
    logic [IN_USER_BITS-1:0]  s_axis_tuser  = '0;   // [1:0] outcome, [7:2] zero
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;         // sequence_res, pings, successes,
                                                    // failures, rtt_min, rtt_max,
                                                    // rtt_average, rtt_range, jitter,
                                                    // loss_permille, zero pad
    logic                     m_axis_tuser;         // skipped

    // Local copy of the statistics state
    logic [SEQ_BITS-1:0]       seq_count;
    logic [SKIP_BITS-1:0]      skip_left;
    logic [CNT_FIELD_BITS-1:0] ping_total;
    logic [CNT_FIELD_BITS-1:0] success_total;
    logic [CNT_FIELD_BITS-1:0] failure_total;
    logic [55:0]               rtt_sum;
    logic [RTT_FIELD_BITS-1:0] min_seen;
    logic [RTT_FIELD_BITS-1:0] max_seen;
    logic [RTT_FIELD_BITS-1:0] previous_rtt;
    logic                      previous_valid;
    logic [55:0]               jitter_sum;
    logic [CNT_FIELD_BITS-1:0] jitter_pairs;

    las_result_t pending_stats[$];

    int  error_count   = 0;
    int  sent_count    = 0;
    int  checked_count = 0;
    int  skipped_seen  = 0;
    int  skip_writes   = 0;
    int  cycle_count   = 0;
    int  stall_token   = 0;
    int  stall_seen    = 0;
    int  hold_left     = 0;
    bit  quiet_mode    = 1'b0;

    latency_statistics_accumulator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #CLK_HALF clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_stats.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Truncating quotient, clamped, zero on a zero divisor
    function automatic logic [63:0] sat_quot(input logic [63:0] num,
                                             input logic [63:0] den,
                                             input logic [63:0] limit);
        logic [63:0] q;
        if (den == 0)
            return 64'd0;
        q = num / den;
        return (q > limit) ? limit : q;
    endfunction

    // Apply one probe to the local state and return the record it produces
    function automatic las_result_t advance_stats(input logic [OUTCOME_BITS-1:0] outcome,
                                                  input logic [RTT_FIELD_BITS-1:0] rtt);
        las_result_t               rec;
        logic [RTT_FIELD_BITS-1:0] diff;
        logic                      skip_now;
        seq_count = seq_count + 1'b1;
        skip_now  = (skip_left != 0);
        if (skip_now)
            skip_left = skip_left - 1'b1;
        else
        begin
            ping_total = ping_total + 1'b1;
            if (outcome == OUTCOME_SUCCESS && rtt != 0)
            begin
                success_total = success_total + 1'b1;
                rtt_sum       = rtt_sum + rtt;
                if (previous_valid)
                begin
                    diff         = (previous_rtt > rtt) ? previous_rtt - rtt : rtt - previous_rtt;
                    jitter_sum   = jitter_sum + diff;
                    jitter_pairs = jitter_pairs + 1'b1;
                    if (rtt < min_seen) min_seen = rtt;
                    if (rtt > max_seen) max_seen = rtt;
                end
                else
                begin
                    // first success seeds both extremes, no jitter pair yet
                    min_seen       = rtt;
                    max_seen       = rtt;
                    previous_valid = 1'b1;
                end
                previous_rtt = rtt;
            end
            else
                failure_total = failure_total + 1'b1;
        end
        rec.sequence_res  = seq_count;
        rec.skipped       = skip_now;
        rec.pings         = ping_total;
        rec.successes     = success_total;
        rec.failures      = failure_total;
        rec.rtt_min       = min_seen;
        rec.rtt_max       = max_seen;
        rec.rtt_average   = RTT_FIELD_BITS'(sat_quot({8'd0, rtt_sum}, {32'd0, success_total},
                                                     {40'd0, RTT_TOP}));
        rec.rtt_range     = max_seen - min_seen;
        rec.jitter        = RTT_FIELD_BITS'(sat_quot({8'd0, jitter_sum}, {32'd0, jitter_pairs},
                                                     {40'd0, RTT_TOP}));
        rec.loss_permille = LOSS_BITS'(sat_quot({32'd0, failure_total} * 64'd1000,
                                                {32'd0, ping_total}, 64'd1000));
        return rec;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    // Compare the result on the bus with the oldest prediction
    task automatic compare_result();
        las_result_t want;
        if (pending_stats.size() == 0)
        begin
            $error("result with no outstanding request, sequence %0d", m_axis_tdata[31:0]);
            error_count++;
            return;
        end
        want = pending_stats.pop_front();
        checked_count++;
        if (m_axis_tuser) skipped_seen++;
        check_field("sequence_res",  64'(want.sequence_res),  64'(m_axis_tdata[31:0]));
        check_field("skipped",       64'(want.skipped),       64'(m_axis_tuser));
        check_field("pings",         64'(want.pings),         64'(m_axis_tdata[63:32]));
        check_field("successes",     64'(want.successes),     64'(m_axis_tdata[95:64]));
        check_field("failures",      64'(want.failures),      64'(m_axis_tdata[127:96]));
        check_field("rtt_min",       64'(want.rtt_min),
                    64'(m_axis_tdata[OUT_MIN_LSB +: 24]));
        check_field("rtt_max",       64'(want.rtt_max),
                    64'(m_axis_tdata[OUT_MAX_LSB +: 24]));
        check_field("rtt_average",   64'(want.rtt_average),   64'(m_axis_tdata[176 +: 24]));
        check_field("rtt_range",     64'(want.rtt_range),     64'(m_axis_tdata[200 +: 24]));
        check_field("jitter",        64'(want.jitter),        64'(m_axis_tdata[224 +: 24]));
        check_field("loss_permille", 64'(want.loss_permille),
                    64'(m_axis_tdata[OUT_LOSS_LSB +: 10]));
    endtask

    // Result side: check accepted results, drive tready with random idling
    // and a counted long hold-off when a test asks for one
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                compare_result();
            if (hold_left != 0)
            begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (stall_token != stall_seen)
            begin
                stall_seen    <= stall_token;
                hold_left     <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= quiet_mode || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Offer one probe request and wait for it to be taken
    task automatic send_probe(input logic [OUTCOME_BITS-1:0] outcome,
                              input logic [RTT_FIELD_BITS-1:0] rtt);
        while (!quiet_mode && $urandom_range(99) < IDLE_PERCENT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rtt;
        s_axis_tuser  <= {{(IN_USER_BITS-OUTCOME_BITS){1'b0}}, outcome};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_stats.push_back(advance_stats(outcome, rtt));
        sent_count++;
    endtask

    // Stop offering and wait until every predicted result has arrived
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge clk);
    endtask

    // Skip count write; only called with the block drained
    task automatic write_skip(input logic [SKIP_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        skip_left = value;
        skip_writes++;
    endtask

    // Random probe, mostly successes with times from several ranges
    task automatic send_random_probe();
        int                        pick;
        logic [RTT_FIELD_BITS-1:0] rtt;
        logic [OUTCOME_BITS-1:0]   outcome;
        pick = $urandom_range(99);
        case ($urandom_range(9))
            0, 1, 2, 3, 4: rtt = RTT_FIELD_BITS'($urandom_range(2000, 1));
            5, 6:          rtt = RTT_FIELD_BITS'($urandom());
            7:             rtt = RTT_TOP - RTT_FIELD_BITS'($urandom_range(255));
            8:             rtt = 24'd1 << $urandom_range(23);
            default:       rtt = '0;
        endcase
        if (pick < 72)      outcome = OUTCOME_SUCCESS;
        else if (pick < 84) outcome = OUTCOME_TIMEOUT;
        else if (pick < 94) outcome = OUTCOME_ERROR;
        else                outcome = OUTCOME_UNUSED;
        send_probe(outcome, rtt);
    endtask

    // Failure codes before any success, zero time on success
    task automatic test_outcome_codes();
        send_probe(OUTCOME_TIMEOUT, 24'd0);
        send_probe(OUTCOME_ERROR,   RTT_TOP);
        send_probe(OUTCOME_UNUSED,  24'h5A5A5A);
        send_probe(OUTCOME_SUCCESS, 24'd0);
        wait_results_drained();
    endtask

    // First success, smallest and largest times, jitter across extremes
    task automatic test_rtt_extremes();
        send_probe(OUTCOME_SUCCESS, 24'd1);
        send_probe(OUTCOME_SUCCESS, RTT_TOP);
        send_probe(OUTCOME_SUCCESS, 24'd1);
        send_probe(OUTCOME_TIMEOUT, RTT_TOP);
        send_probe(OUTCOME_SUCCESS, 24'h800000);
        send_probe(OUTCOME_ERROR,   24'd0);
        send_probe(OUTCOME_SUCCESS, 24'h123456);
        wait_results_drained();
    endtask

    // Short skip window: skipped probes leave the statistics alone
    task automatic test_skip_window();
        write_skip(16'd3);
        send_probe(OUTCOME_SUCCESS, 24'd7);
        send_probe(OUTCOME_TIMEOUT, 24'd0);
        send_probe(OUTCOME_SUCCESS, RTT_TOP);
        send_probe(OUTCOME_SUCCESS, 24'd900);
        wait_results_drained();
    endtask

    // Largest skip count, then reloaded to zero and one mid-window
    task automatic test_skip_extremes();
        write_skip(SKIP_TOP);
        send_probe(OUTCOME_SUCCESS, 24'd42);
        send_probe(OUTCOME_ERROR,   24'd0);
        send_probe(OUTCOME_SUCCESS, 24'd1000);
        wait_results_drained();
        write_skip(16'd0);
        send_probe(OUTCOME_SUCCESS, 24'd250);
        wait_results_drained();
        write_skip(16'd1);
        send_probe(OUTCOME_SUCCESS, 24'd3);
        send_probe(OUTCOME_SUCCESS, 24'd5000);
        wait_results_drained();
    endtask

    // Result side holds off while requests keep coming, so input stalls
    task automatic test_output_stall();
        stall_token++;
        repeat (10)
            send_random_probe();
        wait_results_drained();
    endtask

    // Random phases, each after a drain and a new skip count
    task automatic test_random_traffic();
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_results_drained();
            case (phase)
                0:       write_skip(16'd0);
                1:       write_skip(16'($urandom_range(40, 1)));
                2:       write_skip(16'd0);
                default: write_skip(16'($urandom_range(15)));
            endcase
            // one phase runs with no idling on either side
            quiet_mode = (phase == 2);
            for (int n = 0; n < PHASE_REQUESTS; n++)
                send_random_probe();
        end
        wait_results_drained();
        quiet_mode = 1'b0;
    endtask

    initial
    begin
        seq_count      = '0;
        skip_left      = '0;
        ping_total     = '0;
        success_total  = '0;
        failure_total  = '0;
        rtt_sum        = '0;
        min_seen       = '0;
        max_seen       = '0;
        previous_rtt   = '0;
        previous_valid = 1'b0;
        jitter_sum     = '0;
        jitter_pairs   = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_outcome_codes();
        test_rtt_extremes();
        test_skip_window();
        test_skip_extremes();
        test_output_stall();
        test_random_traffic();

        // stray results would show up here as unmatched
        wait_results_drained();
        repeat (2 * RESULT_LATENCY) @(posedge clk);

        $display("Sent %0d probe requests, checked %0d results (%0d skipped)",
                 sent_count, checked_count, skipped_seen);
        $display("Skip count written %0d times, %0d mismatches, %0d cycles",
                 skip_writes, error_count, cycle_count);
        if (error_count == 0 && pending_stats.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
